// File: rtl/ru_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ru_pkg: shared definitions for the range unwrapper
// Default widths, register reset values, register indexes, state encodings
// and the queue status bundle.
// ----------------------------------------------------------------------------
package ru_pkg;

   localparam int SAMPLE_WIDTH    = 16;
   localparam int COUNT_WIDTH     = 16;
   localparam int OUT_WIDTH       = 32;
   localparam int QUEUE_DEPTH     = 2;
   localparam int CSR_INDEX_WIDTH = 1;

   localparam int BOUND_ONE_RESET = -12868;
   localparam int BOUND_TWO_RESET = 12868;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_BOUND_ONE = 1'b0,
      CSR_BOUND_TWO = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      FR_IDLE,
      FR_DIV,
      FR_DONE
   } front_state_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_MUL,
      BK_ADD
   } back_state_type;

   typedef struct packed {
      logic empty;
      logic full;
   } qstat_type;

endpackage

// File: rtl/ru_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ru_queue: small register queue
// First-in first-out store with push/pop and an empty/full status bundle.
// ----------------------------------------------------------------------------
module ru_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = ru_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  logic [WIDTH-1:0]   wr_data,
   input  logic               pop,
   output logic [WIDTH-1:0]   rd_data,
   output ru_pkg::qstat_type  stat
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push_ok, pop_ok;

   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == CNT_W'(DEPTH));
   assign push_ok    = push & ~stat.full;
   assign pop_ok     = pop & ~stat.empty;
   assign rd_data    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push_ok, pop_ok})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// File: rtl/ru_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ru_front: request intake and range reduction
// Holds the bound registers, accepts a request, and splits the sample offset
// into floor quotient and remainder with a bit-serial divider.
// ----------------------------------------------------------------------------
module ru_front #(
   parameter int SAMPLE_WIDTH = ru_pkg::SAMPLE_WIDTH,
   parameter int ENTRY_W      = 3 * SAMPLE_WIDTH + 3
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     csr_wr_en,
   input  logic [ru_pkg::CSR_INDEX_WIDTH-1:0]       csr_index,
   input  logic [SAMPLE_WIDTH-1:0]                  csr_data,
   input  logic                                     req_push,
   output logic                                     req_full,
   input  logic signed [SAMPLE_WIDTH-1:0]           req_sample,
   input  logic                                     req_restart,
   input  ru_pkg::qstat_type                        q_stat,
   output logic                                     q_push,
   output logic [ENTRY_W-1:0]                       q_data
);

   localparam int SW    = SAMPLE_WIDTH;
   localparam int CNT_W = $clog2(SW);

   ru_pkg::front_state_type state_ff, state_in;

   logic signed [SW-1:0] bound_one_ff, bound_two_ff;

   logic signed [SW-1:0] sample_ff, sample_in;
   logic                 restart_ff, restart_in;
   logic signed [SW-1:0] lo_ff, lo_in;
   logic        [SW-1:0] span_ff, span_in;
   logic                 neg_ff, neg_in;
   logic                 pass_ff, pass_in;
   logic        [SW-1:0] rem_ff, rem_in;
   logic        [SW-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;

   // intake arithmetic
   logic signed [SW-1:0] lo_c, hi_c;
   logic signed [SW:0]   span_w, off_w, mag_w;

   // divide step
   logic [SW:0] rem_sh, diff;
   logic        ge;

   // result assembly
   logic          round_up;
   logic [SW-1:0] r_fin;
   logic [SW:0]   qmag, q_fin, p_w;
   logic [SW-1:0] p_fin;

   assign lo_c   = (bound_one_ff < bound_two_ff) ? bound_one_ff : bound_two_ff;
   assign hi_c   = (bound_one_ff < bound_two_ff) ? bound_two_ff : bound_one_ff;
   assign span_w = {hi_c[SW-1], hi_c} - {lo_c[SW-1], lo_c};
   assign off_w  = {req_sample[SW-1], req_sample} - {lo_c[SW-1], lo_c};
   assign mag_w  = off_w[SW] ? -off_w : off_w;

   assign rem_sh = {rem_ff, quo_ff[SW-1]};
   assign diff   = rem_sh - {1'b0, span_ff};
   assign ge     = (rem_sh >= {1'b0, span_ff});

   // floor correction for a negative offset with a nonzero remainder
   assign round_up = neg_ff & (rem_ff != '0);
   assign r_fin    = round_up ? (span_ff - rem_ff) : rem_ff;
   assign qmag     = {1'b0, quo_ff} + {{SW{1'b0}}, round_up};
   assign q_fin    = neg_ff ? -qmag : qmag;
   assign p_w      = {lo_ff[SW-1], lo_ff} + {1'b0, r_fin};
   assign p_fin    = pass_ff ? sample_ff : p_w[SW-1:0];

   assign q_data   = {pass_ff, restart_ff, p_fin, q_fin, span_ff};
   assign req_full = (state_ff != ru_pkg::FR_IDLE);

   always_comb begin
      state_in   = state_ff;
      sample_in  = sample_ff;
      restart_in = restart_ff;
      lo_in      = lo_ff;
      span_in    = span_ff;
      neg_in     = neg_ff;
      pass_in    = pass_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      cnt_in     = cnt_ff;
      q_push     = 1'b0;
      case (state_ff)
         ru_pkg::FR_IDLE: begin
            if (req_push) begin
               sample_in  = req_sample;
               restart_in = req_restart;
               lo_in      = lo_c;
               span_in    = span_w[SW-1:0];
               neg_in     = off_w[SW];
               pass_in    = (span_w == '0);
               rem_in     = '0;
               quo_in     = mag_w[SW-1:0];
               cnt_in     = CNT_W'(SW - 1);
               state_in   = (span_w == '0) ? ru_pkg::FR_DONE : ru_pkg::FR_DIV;
            end
         end
         ru_pkg::FR_DIV: begin
            rem_in = ge ? diff[SW-1:0] : rem_sh[SW-1:0];
            quo_in = {quo_ff[SW-2:0], ge};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ru_pkg::FR_DONE;
            end
         end
         ru_pkg::FR_DONE: begin
            if (!q_stat.full) begin
               q_push   = 1'b1;
               state_in = ru_pkg::FR_IDLE;
            end
         end
         default: begin
            state_in = ru_pkg::FR_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ru_pkg::FR_IDLE;
         bound_one_ff <= SW'(ru_pkg::BOUND_ONE_RESET);
         bound_two_ff <= SW'(ru_pkg::BOUND_TWO_RESET);
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            case (csr_index)
               ru_pkg::CSR_BOUND_ONE: bound_one_ff <= csr_data;
               ru_pkg::CSR_BOUND_TWO: bound_two_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      sample_ff  <= sample_in;
      restart_ff <= restart_in;
      lo_ff      <= lo_in;
      span_ff    <= span_in;
      neg_ff     <= neg_in;
      pass_ff    <= pass_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      cnt_ff     <= cnt_in;
   end

endmodule

// File: rtl/ru_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ru_back: wrap tracking and output scaling
// Updates the wrap counter and last principal value (not for pass entries), then forms
// principal + span * count with a registered multiply and a saturating add.
// ----------------------------------------------------------------------------
module ru_back #(
   parameter int SAMPLE_WIDTH = ru_pkg::SAMPLE_WIDTH,
   parameter int COUNT_WIDTH  = ru_pkg::COUNT_WIDTH,
   parameter int ENTRY_W      = 3 * SAMPLE_WIDTH + 3
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ru_pkg::qstat_type             in_stat,
   input  logic [ENTRY_W-1:0]            in_data,
   output logic                          in_pop,
   input  ru_pkg::qstat_type             out_stat,
   output logic                          out_push,
   output logic [ru_pkg::OUT_WIDTH:0]    out_data
);

   localparam int SW    = SAMPLE_WIDTH;
   localparam int CW    = COUNT_WIDTH;
   localparam int OW    = ru_pkg::OUT_WIDTH;
   localparam int WIDE  = ((SW + 1 > CW) ? SW + 1 : CW) + 1;
   localparam int PRODW = SW + 1 + CW;
   localparam int SUMW  = PRODW + 1;
   localparam int SATW  = (SUMW > OW + 1) ? SUMW : OW + 1;

   localparam logic signed [WIDE-1:0] CMAX_W = {{(WIDE-CW+1){1'b0}}, {(CW-1){1'b1}}};
   localparam logic signed [WIDE-1:0] CMIN_W = {{(WIDE-CW+1){1'b1}}, {(CW-1){1'b0}}};
   localparam logic signed [CW-1:0]   CMAX   = {1'b0, {(CW-1){1'b1}}};
   localparam logic signed [CW-1:0]   CMIN   = {1'b1, {(CW-1){1'b0}}};
   localparam logic signed [SATW-1:0] OMAX_W = {{(SATW-OW+1){1'b0}}, {(OW-1){1'b1}}};
   localparam logic signed [SATW-1:0] OMIN_W = {{(SATW-OW+1){1'b1}}, {(OW-1){1'b0}}};

   ru_pkg::back_state_type state_ff, state_in;

   // unwrap state
   logic signed [SW-1:0] last_ff, last_in;
   logic signed [CW-1:0] count_ff, count_in;
   logic                 primed_ff, primed_in;

   // datapath registers
   logic signed [SW-1:0]    p_ff, p_in;
   logic signed [SW:0]      span_op_ff, span_op_in;
   logic signed [CW-1:0]    cnt_op_ff, cnt_op_in;
   logic                    sat_ff, sat_in;
   logic signed [PRODW-1:0] prod_ff, prod_in;

   // entry fields
   logic                 e_pass, e_restart;
   logic signed [SW-1:0] e_p;
   logic signed [SW:0]   e_q;
   logic        [SW-1:0] e_span;

   // counter update
   logic signed [SW:0]   d;
   logic signed [SW+1:0] d2, nd2, span_x;
   logic signed [WIDE-1:0] q_w;
   logic signed [CW-1:0] next_cnt;
   logic                 next_sat;

   // output sum
   logic signed [SATW-1:0] sum_w;
   logic                   over, under;
   logic signed [OW-1:0]   res;

   assign e_pass    = in_data[ENTRY_W-1];
   assign e_restart = in_data[ENTRY_W-2];
   assign e_p       = in_data[ENTRY_W-3 -: SW];
   assign e_q       = in_data[SW +: SW+1];
   assign e_span    = in_data[SW-1:0];

   assign d      = {e_p[SW-1], e_p} - {last_ff[SW-1], last_ff};
   assign d2     = {d, 1'b0};
   assign nd2    = -d2;
   assign span_x = {2'b00, e_span};
   assign q_w    = WIDE'(e_q);

   always_comb begin
      next_cnt = count_ff;
      next_sat = 1'b0;
      if (e_restart || !primed_ff) begin
         if (q_w > CMAX_W) begin
            next_cnt = CMAX;
            next_sat = 1'b1;
         end else if (q_w < CMIN_W) begin
            next_cnt = CMIN;
            next_sat = 1'b1;
         end else begin
            next_cnt = q_w[CW-1:0];
         end
      end else if (d2 > span_x) begin
         // forward jump past half a span: the input wrapped downward
         if (count_ff == CMIN) begin
            next_sat = 1'b1;
         end else begin
            next_cnt = count_ff - 1'b1;
         end
      end else if (nd2 > span_x) begin
         if (count_ff == CMAX) begin
            next_sat = 1'b1;
         end else begin
            next_cnt = count_ff + 1'b1;
         end
      end
   end

   assign sum_w = SATW'(prod_ff) + SATW'(p_ff);
   assign over  = (sum_w > OMAX_W);
   assign under = (sum_w < OMIN_W);
   assign res   = over ? OMAX_W[OW-1:0] : (under ? OMIN_W[OW-1:0] : sum_w[OW-1:0]);

   assign out_data = {sat_ff | over | under, res};

   always_comb begin
      state_in   = state_ff;
      last_in    = last_ff;
      count_in   = count_ff;
      primed_in  = primed_ff;
      p_in       = p_ff;
      span_op_in = span_op_ff;
      cnt_op_in  = cnt_op_ff;
      sat_in     = sat_ff;
      prod_in    = prod_ff;
      in_pop     = 1'b0;
      out_push   = 1'b0;
      case (state_ff)
         ru_pkg::BK_IDLE: begin
            // only this unit pushes the result queue, so a free slot now
            // is still free when BK_ADD pushes the result
            if (!in_stat.empty && !out_stat.full) begin
               in_pop   = 1'b1;
               p_in     = e_p;
               state_in = ru_pkg::BK_MUL;
               if (e_pass) begin
                  span_op_in = '0;
                  cnt_op_in  = '0;
                  sat_in     = 1'b0;
               end else begin
                  span_op_in = {1'b0, e_span};
                  cnt_op_in  = next_cnt;
                  sat_in     = next_sat;
                  count_in   = next_cnt;
                  last_in    = e_p;
                  primed_in  = 1'b1;
               end
            end
         end
         ru_pkg::BK_MUL: begin
            prod_in  = span_op_ff * cnt_op_ff;
            state_in = ru_pkg::BK_ADD;
         end
         ru_pkg::BK_ADD: begin
            out_push = 1'b1;
            state_in = ru_pkg::BK_IDLE;
         end
         default: begin
            state_in = ru_pkg::BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ru_pkg::BK_IDLE;
         last_ff   <= '0;
         count_ff  <= '0;
         primed_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         last_ff   <= last_in;
         count_ff  <= count_in;
         primed_ff <= primed_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff       <= p_in;
      span_op_ff <= span_op_in;
      cnt_op_ff  <= cnt_op_in;
      sat_ff     <= sat_in;
      prod_ff    <= prod_in;
   end

endmodule

// File: rtl/range_unwrap.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_unwrap: unwrapper for wrapped fixed-point samples
// Reduces each sample into [low, high) of the configured bounds, tracks wraps
// and returns principal value plus span times wrap count, saturated.
// ----------------------------------------------------------------------------
// Usage: write the two bound registers (either order; the lesser is the low
// end) while no request is outstanding. Each request gives exactly one
// response. A request holds the intake while the one-bit-per-clock floor
// divider reduces the sample into the range and until its entry is pushed
// to the middle queue; a new request is taken only after that. With equal
// bounds the divider is skipped and the sample passes straight through. The
// wrap tracker behind it takes each entry through idle, multiply and add
// states and pops no new entry until it is done. A two-entry queue between
// the divider and the tracker, and another on the response side, let the
// response consumer stall without stalling intake right away.
// ----------------------------------------------------------------------------
module range_unwrap #(
   parameter int SAMPLE_WIDTH = ru_pkg::SAMPLE_WIDTH,
   parameter int COUNT_WIDTH  = ru_pkg::COUNT_WIDTH
) (
   input  logic                                clock,
   input  logic                                reset,
   // configuration writes
   input  logic                                csr_wr_en,
   input  logic [ru_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [SAMPLE_WIDTH-1:0]             csr_data,
   // request side
   input  logic                                req_push,
   output logic                                req_full,
   input  logic signed [SAMPLE_WIDTH-1:0]      req_sample,
   input  logic                                req_restart,
   // response side
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output logic signed [ru_pkg::OUT_WIDTH-1:0] rsp_unwrapped,
   output logic                                rsp_saturated
);

   // queue entry: pass flag, restart, principal, floor quotient, span
   localparam int ENTRY_W = 3 * SAMPLE_WIDTH + 3;
   localparam int RSP_W   = ru_pkg::OUT_WIDTH + 1;

   ru_pkg::qstat_type   mid_stat, rsp_stat;
   logic                mid_push, mid_pop, rsp_push;
   logic [ENTRY_W-1:0]  mid_wr, mid_rd;
   logic [RSP_W-1:0]    rsp_wr, rsp_rd;

   // Intake: bound registers, request accept, range reduction.
   ru_front #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .ENTRY_W      (ENTRY_W)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_sample  (req_sample),
      .req_restart (req_restart),
      .q_stat      (mid_stat),
      .q_push      (mid_push),
      .q_data      (mid_wr)
   );

   // Decouples the divider from the wrap tracker.
   ru_queue #(
      .WIDTH (ENTRY_W),
      .DEPTH (ru_pkg::QUEUE_DEPTH)
   ) u_mid_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (mid_push),
      .wr_data (mid_wr),
      .pop     (mid_pop),
      .rd_data (mid_rd),
      .stat    (mid_stat)
   );

   // Wrap counter state and output scaling.
   ru_back #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .COUNT_WIDTH  (COUNT_WIDTH),
      .ENTRY_W      (ENTRY_W)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .in_stat  (mid_stat),
      .in_data  (mid_rd),
      .in_pop   (mid_pop),
      .out_stat (rsp_stat),
      .out_push (rsp_push),
      .out_data (rsp_wr)
   );

   // Response queue; its head is what the response ports show.
   ru_queue #(
      .WIDTH (RSP_W),
      .DEPTH (ru_pkg::QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (rsp_push),
      .wr_data (rsp_wr),
      .pop     (rsp_pop),
      .rd_data (rsp_rd),
      .stat    (rsp_stat)
   );

   assign rsp_empty     = rsp_stat.empty;
   assign rsp_unwrapped = rsp_rd[ru_pkg::OUT_WIDTH-1:0];
   assign rsp_saturated = rsp_rd[ru_pkg::OUT_WIDTH];

endmodule

// File: rtl/ru_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ru_checker: port-level checks for the range unwrapper
// Watches the request and response queues of the top level over time.
// ----------------------------------------------------------------------------
module ru_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_push,
   input logic                                req_full,
   input logic                                rsp_empty,
   input logic                                rsp_pop,
   input logic signed [ru_pkg::OUT_WIDTH-1:0] rsp_unwrapped,
   input logic                                rsp_saturated
);

   // no response survives reset
   a_reset_empty : assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("response queue not empty after reset");

   // intake is open right after reset
   a_reset_open : assert property (@(posedge clock) reset |=> !req_full)
      else $error("request side full after reset");

   // the intake turns busy once it accepts a request
   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      (req_push && !req_full) |=> req_full)
      else $error("intake open directly after accepting a request");

   // a waiting response that is not taken stays put
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
         (!rsp_empty && $stable(rsp_unwrapped) && $stable(rsp_saturated)))
      else $error("waiting response changed or vanished");

endmodule

bind range_unwrap ru_checker u_ru_checker (
   .clock         (clock),
   .reset         (reset),
   .req_push      (req_push),
   .req_full      (req_full),
   .rsp_empty     (rsp_empty),
   .rsp_pop       (rsp_pop),
   .rsp_unwrapped (rsp_unwrapped),
   .rsp_saturated (rsp_saturated)
);

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for range_unwrap
// Walks a directed table of requests and bound writes, then runs phases of
// random wrapped-phase streams over many bound settings. Every response is
// checked against the plan or the in-bench predictor; both queue sides stall.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int     SW             = ru_pkg::SAMPLE_WIDTH;
   localparam int     CW             = ru_pkg::COUNT_WIDTH;
   localparam int     OW             = ru_pkg::OUT_WIDTH;
   localparam longint SMP_MAX        = (longint'(1) << (SW - 1)) - 1;
   localparam longint SMP_MIN        = -(longint'(1) << (SW - 1));
   localparam longint CNT_MAX        = (longint'(1) << (CW - 1)) - 1;
   localparam longint CNT_MIN        = -(longint'(1) << (CW - 1));
   localparam longint OUT_MAX        = (longint'(1) << (OW - 1)) - 1;
   localparam longint OUT_MIN        = -(longint'(1) << (OW - 1));
   localparam int     SETTLE_CYCLES  = 8;     // idle margin before a bound write
   localparam int     TAIL_CYCLES    = 40;    // idle run-out before the final status
   localparam int     LONG_HOLD      = 400;   // response side hold-off
   localparam int     WATCHDOG_LIMIT = 4000;  // cycles with no transfer at all
   localparam int     PHASES         = 12;
   localparam int     PHASE_ITEMS    = 58;
   localparam int     PLAN_ROWS      = 29;

   typedef enum logic {ROW_REQUEST, ROW_BOUNDS} row_kind_type;

   // One line of the directed plan. A request row carries the sample in
   // field a; a bounds row carries bound_one in a and bound_two in b. Where
   // known is set the response is written out here instead of predicted.
   typedef struct packed {
      row_kind_type           kind;
      logic signed [SW-1:0]   a;
      logic signed [SW-1:0]   b;
      logic                   restart;
      logic                   known;
      logic signed [31:0]     unwrapped;
      logic                   saturated;
   } plan_row_type;

   typedef struct packed {
      logic signed [31:0] unwrapped;
      logic               saturated;
   } result_type;

   // ------------------------------------------------------------------------
   // DUT hookup; every input starts at a known value
   // ------------------------------------------------------------------------
   logic                      clock         = 1'b0;
   logic                      reset         = 1'b1;
   logic                      csr_wr_en     = 1'b0;
   ru_pkg::csr_index_type     csr_index     = ru_pkg::CSR_BOUND_ONE;
   logic [SW-1:0]             csr_data      = '0;
   logic                      req_push      = 1'b0;
   logic                      req_full;
   logic signed [SW-1:0]      req_sample    = '0;
   logic                      req_restart   = 1'b0;
   logic                      rsp_empty;
   logic                      rsp_pop       = 1'b0;
   logic signed [OW-1:0]      rsp_unwrapped;
   logic                      rsp_saturated;

   range_unwrap u_top (
      .clock,
      .reset,
      .csr_wr_en,
      .csr_index,
      .csr_data,
      .req_push,
      .req_full,
      .req_sample,
      .req_restart,
      .rsp_empty,
      .rsp_pop,
      .rsp_unwrapped,
      .rsp_saturated
   );

   always #6 clock = ~clock;

   // Side-band that travels with each request: a response typed into the
   // plan, when there is one.
   logic                      row_known     = 1'b0;
   logic signed [31:0]        row_unwrapped = '0;
   logic                      row_saturated = 1'b0;

   // Stimulus control shared between the request and response processes.
   bit                        quiet_tail    = 1'b0;  // no idling on either side
   bit                        tx_calm       = 1'b0;  // request side never idles
   bit                        hold_ask      = 1'b0;  // raised by sender, cleared by sink

   // ------------------------------------------------------------------------
   // Unwrap predictor: bound mirror plus its own copy of the tracker state
   // ------------------------------------------------------------------------
   logic signed [SW-1:0]          bnd_one;
   logic signed [SW-1:0]          bnd_two;
   logic signed [SW-1:0]          last_phase;
   logic signed [CW-1:0]          wrap_turns;
   bit                            seeded;

   result_type pending_results[$];
   int         mismatch_count = 0;

   function automatic result_type unwrap_predict(input logic signed [SW-1:0] smp,
                                                 input logic restart);
      longint     s, b1, b2, lo, span, off, r, p, k, d, sum;
      result_type res;
      s    = smp;
      b1   = bnd_one;
      b2   = bnd_two;
      lo   = (b1 < b2) ? b1 : b2;
      span = ((b1 < b2) ? b2 : b1) - lo;
      res.saturated = 1'b0;
      if (span == 0) begin
         // equal bounds: straight pass, tracker untouched even on restart
         sum = s;
      end else begin
         // floor modulo into [lo, hi)
         off = s - lo;
         r   = off % span;
         if (r < 0) r += span;
         p = lo + r;
         if (restart || !seeded) begin
            k      = (off - r) / span;
            seeded = 1'b1;
         end else begin
            // a jump of more than half the span counts as one wrap against it
            k = wrap_turns;
            d = p - last_phase;
            if (2 * d > span)
               k = k - 1;
            else if (-2 * d > span)
               k = k + 1;
         end
         if (k > CNT_MAX) begin
            k = CNT_MAX;
            res.saturated = 1'b1;
         end else if (k < CNT_MIN) begin
            k = CNT_MIN;
            res.saturated = 1'b1;
         end
         wrap_turns = k[CW-1:0];
         last_phase = p[SW-1:0];
         sum = p + span * k;
      end
      if (sum > OUT_MAX) begin
         sum = OUT_MAX;
         res.saturated = 1'b1;
      end else if (sum < OUT_MIN) begin
         sum = OUT_MIN;
         res.saturated = 1'b1;
      end
      res.unwrapped = sum[31:0];
      return res;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      mismatch_count++;
      $display("mismatch %s: got %0d want %0d (%0d responses pending)",
               what, got, want, pending_results.size());
   endtask

   // ------------------------------------------------------------------------
   // Scoreboard: sampled at the edge, so it sees the values the DUT saw.
   // A response is checked before the request of the same edge is queued.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : scoreboard
      result_type want;
      result_type pred;
      if (reset) begin
         bnd_one    = SW'(ru_pkg::BOUND_ONE_RESET);
         bnd_two    = SW'(ru_pkg::BOUND_TWO_RESET);
         last_phase = '0;
         wrap_turns = '0;
         seeded     = 1'b0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               ru_pkg::CSR_BOUND_ONE: bnd_one = csr_data;
               ru_pkg::CSR_BOUND_TWO: bnd_two = csr_data;
               default: ;
            endcase
         end
         if (rsp_pop && !rsp_empty) begin
            if (pending_results.size() == 0) begin
               report_mismatch("response with no request pending", rsp_unwrapped, 0);
            end else begin
               want = pending_results.pop_front();
               if (rsp_unwrapped !== want.unwrapped)
                  report_mismatch("unwrapped", rsp_unwrapped, want.unwrapped);
               if (rsp_saturated !== want.saturated)
                  report_mismatch("saturated", rsp_saturated, want.saturated);
            end
         end
         if (req_push && !req_full) begin
            // always run the predictor so its state follows the stream
            pred = unwrap_predict(req_sample, req_restart);
            if (row_known) begin
               want.unwrapped = row_unwrapped;
               want.saturated = row_saturated;
               pending_results.insert(pending_results.size(), want);
            end else begin
               pending_results.insert(pending_results.size(), pred);
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------------

   // Offer one request and hold it until the intake takes it. Push stays high
   // on return so back-to-back requests need no extra edge.
   task automatic offer_request(input logic signed [SW-1:0] smp, input logic restart,
                                input logic known, input logic signed [31:0] unw,
                                input logic sat);
      if (!quiet_tail && !tx_calm && $urandom_range(0, 4) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_push      <= 1'b1;
      req_sample    <= smp;
      req_restart   <= restart;
      row_known     <= known;
      row_unwrapped <= unw;
      row_saturated <= sat;
      @(posedge clock);
      while (req_full) @(posedge clock);
   endtask

   // Stop offering and wait until every queued response has come back.
   // Checked at the falling edge, after the scoreboard has settled.
   task automatic drain_results();
      req_push <= 1'b0;
      do @(negedge clock); while (pending_results.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_bounds(input logic signed [SW-1:0] one,
                               input logic signed [SW-1:0] two);
      csr_wr_en <= 1'b1;
      csr_index <= ru_pkg::CSR_BOUND_ONE;
      csr_data  <= one;
      @(posedge clock);
      csr_index <= ru_pkg::CSR_BOUND_TWO;
      csr_data  <= two;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // One random phase at fixed bounds. Most requests follow a drifting phase
   // walk folded into the range, so wraps both ways are frequent; some are
   // shifted by one span, the rest are raw noise, and any may carry a restart.
   task automatic run_phase(input logic signed [SW-1:0] b1, input logic signed [SW-1:0] b2,
                            input bit hold, input bit pause);
      longint               lo, span, walk, step, pr;
      logic signed [SW-1:0] smp;
      logic                 restart;
      int                   pick;
      bit                   rising;
      drain_results();
      write_bounds(b1, b2);
      lo      = (b1 < b2) ? b1 : b2;
      span    = ((b1 < b2) ? b2 : b1) - lo;
      walk    = lo + longint'($urandom_range(0, int'(span)));
      rising  = $urandom_range(0, 1);
      tx_calm = ($urandom_range(0, 3) == 0);
      if (hold) hold_ask = 1'b1;   // sink stalls while we keep offering
      for (int i = 0; i < PHASE_ITEMS; i++) begin
         if (pause && i == PHASE_ITEMS / 2) drain_results();
         pick    = $urandom_range(0, 99);
         restart = ($urandom_range(0, 24) == 0);
         if (span == 0 || pick < 15) begin
            smp = SW'($urandom);
         end else begin
            if (pick < 70)
               step = $urandom_range(0, int'(span / 4));
            else
               step = $urandom_range(0, int'(span / 2));   // half span exactly too
            if ($urandom_range(0, 4) == 0) rising = !rising;
            walk = rising ? walk + step : walk - step;
            pr = (walk - lo) % span;
            if (pr < 0) pr += span;
            pr += lo;
            if (pick >= 90 && pr + span <= SMP_MAX)
               pr += span;
            else if (pick >= 90 && pr - span >= SMP_MIN)
               pr -= span;
            smp = pr[SW-1:0];
         end
         offer_request(smp, restart, 1'b0, '0, 1'b0);
      end
   endtask

   // Directed plan. Typed responses: first request after reset, restarts and
   // equal bounds pass the sample through; a seed beyond the counter range
   // clamps. The rest cover range edges, the high bound folding to the low,
   // reversed bounds, bounds changed under a live counter, and a step past
   // the counter limit in both directions.
   plan_row_type plan [PLAN_ROWS] = '{
      '{ROW_REQUEST,  16'sd32767,  16'sd0,     1'b0, 1'b1,  32'sd32767, 1'b0},
      '{ROW_REQUEST,  16'sd0,      16'sd0,     1'b0, 1'b0,  32'sd0,     1'b0},
      '{ROW_REQUEST,  16'sh8000,   16'sd0,     1'b0, 1'b0,  32'sd0,     1'b0},
      '{ROW_REQUEST,  16'sd12867,  16'sd0,     1'b0, 1'b0,  32'sd0,     1'b0},
      '{ROW_REQUEST, -16'sd12868,  16'sd0,     1'b0, 1'b0,  32'sd0,     1'b0},
      '{ROW_REQUEST,  16'sd12868,  16'sd0,     1'b0, 1'b0,  32'sd0,     1'b0},
      '{ROW_REQUEST,  16'sd0,      16'sd0,     1'b1, 1'b1,  32'sd0,     1'b0},
      '{ROW_REQUEST,  16'sh8000,   16'sd0,     1'b1, 1'b1, -32'sd32768, 1'b0},
      '{ROW_REQUEST,  16'sd25000,  16'sd0,     1'b0, 1'b0,  32'sd0,     1'b0},
      '{ROW_REQUEST, -16'sd25000,  16'sd0,     1'b0, 1'b0,  32'sd0,     1'b0},
      // equal bounds
      '{ROW_BOUNDS,   16'sd5,      16'sd5,     1'b0, 1'b0,  32'sd0,     1'b0},
      '{ROW_REQUEST,  16'sd32767,  16'sd0,     1'b0, 1'b1,  32'sd32767, 1'b0},
      '{ROW_REQUEST,  16'sh8000,   16'sd0,     1'b1, 1'b1, -32'sd32768, 1'b0},
      '{ROW_REQUEST, -16'sd1,      16'sd0,     1'b0, 1'b1, -32'sd1,     1'b0},
      // span of one at the bottom, bounds given high first: seed clamps high
      '{ROW_BOUNDS,  -16'sd32767,  16'sh8000,  1'b0, 1'b0,  32'sd0,     1'b0},
      '{ROW_REQUEST,  16'sd32767,  16'sd0,     1'b1, 1'b1, -32'sd1,     1'b1},
      // widen to three under the clamped counter, then wrap upward past it
      '{ROW_BOUNDS,  -16'sd32765,  16'sh8000,  1'b0, 1'b0,  32'sd0,     1'b0},
      '{ROW_REQUEST, -16'sd32767,  16'sd0,     1'b0, 1'b0,  32'sd0,     1'b0},
      '{ROW_REQUEST, -16'sd32766,  16'sd0,     1'b0, 1'b0,  32'sd0,     1'b0},
      '{ROW_REQUEST,  16'sh8000,   16'sd0,     1'b0, 1'b0,  32'sd0,     1'b0},
      // span of one at the top: seed clamps low
      '{ROW_BOUNDS,   16'sd32767,  16'sd32766, 1'b0, 1'b0,  32'sd0,     1'b0},
      '{ROW_REQUEST,  16'sh8000,   16'sd0,     1'b1, 1'b1, -32'sd2,     1'b1},
      '{ROW_BOUNDS,   16'sd32767,  16'sd32764, 1'b0, 1'b0,  32'sd0,     1'b0},
      '{ROW_REQUEST,  16'sd32765,  16'sd0,     1'b0, 1'b0,  32'sd0,     1'b0},
      '{ROW_REQUEST,  16'sd32764,  16'sd0,     1'b0, 1'b0,  32'sd0,     1'b0},
      '{ROW_REQUEST,  16'sd32766,  16'sd0,     1'b0, 1'b0,  32'sd0,     1'b0},
      // widest range
      '{ROW_BOUNDS,   16'sh8000,   16'sd32767, 1'b0, 1'b0,  32'sd0,     1'b0},
      '{ROW_REQUEST,  16'sd32767,  16'sd0,     1'b0, 1'b0,  32'sd0,     1'b0},
      '{ROW_REQUEST,  16'sd32766,  16'sd0,     1'b1, 1'b0,  32'sd0,     1'b0}
   };

   initial begin : request_source
      int                   lo_i;
      int                   span_i;
      logic signed [SW-1:0] b1;
      logic signed [SW-1:0] b2;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_BOUNDS) begin
            drain_results();
            write_bounds(plan[i].a, plan[i].b);
         end else begin
            offer_request(plan[i].a, plan[i].restart, plan[i].known,
                          plan[i].unwrapped, plan[i].saturated);
         end
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph % 6)
            0: begin   // anywhere
               b1 = SW'($urandom);
               b2 = SW'($urandom);
            end
            1: begin   // tiny span
               lo_i   = int'($urandom_range(0, 65523)) - 32768;
               span_i = $urandom_range(1, 12);
               b1 = SW'(lo_i);
               b2 = SW'(lo_i + span_i);
               if ($urandom_range(0, 1)) begin
                  b1 = SW'(lo_i + span_i);
                  b2 = SW'(lo_i);
               end
            end
            2: begin   // full range, both orders over the run
               b1 = (ph < 6) ? 16'sh8000 : 16'sd32767;
               b2 = (ph < 6) ? 16'sd32767 : 16'sh8000;
            end
            3: begin   // equal bounds
               b1 = SW'($urandom);
               b2 = b1;
            end
            4: begin   // power-on setting
               b1 = SW'(ru_pkg::BOUND_ONE_RESET);
               b2 = SW'(ru_pkg::BOUND_TWO_RESET);
            end
            default: begin
               lo_i   = int'($urandom_range(0, 32768)) - 32768;
               span_i = $urandom_range(100, 20000);
               b1 = SW'(lo_i + span_i);
               b2 = SW'(lo_i);
            end
         endcase
         if (ph == PHASES - 1) quiet_tail = 1'b1;
         // phase 2: long sink hold while requests keep coming;
         // phase 4: sender waits mid-phase for every response
         run_phase(b1, b2, ph == 2, ph == 4);
      end

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Response side: random stall bursts, calm stretches and one long hold
   // ------------------------------------------------------------------------
   initial begin : response_sink
      int rx_calm;
      rx_calm = 0;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         if (hold_ask) begin
            rsp_pop <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_ask = 1'b0;
         end else if (!quiet_tail && rx_calm == 0 && $urandom_range(0, 5) == 0) begin
            rsp_pop <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
            if ($urandom_range(0, 7) == 0) rx_calm = $urandom_range(40, 160);
         end else begin
            rsp_pop <= 1'b1;
            if (rx_calm != 0) rx_calm--;
            @(posedge clock);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Watchdog: too long with no request, response or bound write means hung
   // ------------------------------------------------------------------------
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || csr_wr_en || (req_push && !req_full) || (rsp_pop && !rsp_empty))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("status: fail");
      $finish;
   end

endmodule
